[src/lsc_pkg.sv]
// Shared types and constants for the line segment clipper.
package lsc_pkg;

  localparam int COORD_BITS  = 16;
  localparam int T_FRAC_BITS = 16;

  // Coordinate differences need one bit more than a coordinate
  localparam int DW = COORD_BITS + 1;
  // Parameter t in [0, 1.0] plus one saturation code above 1.0
  localparam int TW = T_FRAC_BITS + 1;
  // Product of t and a difference
  localparam int PW = TW + 1 + DW;
  localparam int NB = 4;
  localparam int DATA_W = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int CFG_IDX_W = 8;

  localparam logic [TW-1:0] T_ONE = TW'(1) << T_FRAC_BITS;
  localparam logic [TW-1:0] T_SAT = T_ONE + TW'(1);
  localparam logic [PW-1:0] T_HALF = PW'(1) << (T_FRAC_BITS - 1);

  localparam logic [CFG_IDX_W-1:0] REG_X_MIN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_X_MAX = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_Y_MIN = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_Y_MAX = CFG_IDX_W'(3);

  localparam logic [COORD_BITS-1:0] RST_X_MIN = COORD_BITS'(0);
  localparam logic [COORD_BITS-1:0] RST_X_MAX = COORD_BITS'(1279);
  localparam logic [COORD_BITS-1:0] RST_Y_MIN = COORD_BITS'(0);
  localparam logic [COORD_BITS-1:0] RST_Y_MAX = COORD_BITS'(799);

  // One boundary's division in flight: divisor, partial remainder, quotient so far
  typedef struct packed {
    logic [DW-1:0] dv;
    logic [DW-1:0] rem;
    logic          lsb;
    logic [TW-1:0] quo;
  } lane_t;

  typedef lane_t [NB-1:0] lanes_t;

  // Data that rides along the divider chain
  typedef struct packed {
    logic                  valid;
    logic                  rej;
    logic [NB-1:0]         pz;
    logic [NB-1:0]         enter;
    logic [NB-1:0]         tneg;
    logic [NB-1:0]         sat;
    logic [COORD_BITS-1:0] sx;
    logic [COORD_BITS-1:0] sy;
    logic [DW-1:0]         dx;
    logic [DW-1:0]         dy;
  } side_t;

  typedef struct packed {
    logic                  valid;
    logic                  visible;
    logic [COORD_BITS-1:0] x0;
    logic [COORD_BITS-1:0] y0;
    logic [COORD_BITS-1:0] x1;
    logic [COORD_BITS-1:0] y1;
  } res_t;

endpackage

[src/lsc_div_cell.sv]
// One restoring division step for all four boundaries, registered.
module lsc_div_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  lsc_pkg::lanes_t lanes_i,
  input  lsc_pkg::side_t  side_i,
  output lsc_pkg::lanes_t lanes_o,
  output lsc_pkg::side_t  side_o
);

  lsc_pkg::lanes_t lanes_nxt;
  lsc_pkg::lanes_t lanes_r;
  lsc_pkg::side_t  side_r;

  always_comb begin
    logic [lsc_pkg::DW:0] r2;
    logic [lsc_pkg::DW:0] dif;
    logic                 ge;
    for (int i = 0; i < lsc_pkg::NB; i++) begin
      r2  = {lanes_i[i].rem, lanes_i[i].lsb};
      dif = r2 - {1'b0, lanes_i[i].dv};
      ge  = (r2 >= {1'b0, lanes_i[i].dv});
      lanes_nxt[i].dv  = lanes_i[i].dv;
      lanes_nxt[i].rem = ge ? dif[lsc_pkg::DW-1:0] : r2[lsc_pkg::DW-1:0];
      lanes_nxt[i].lsb = 1'b0;
      lanes_nxt[i].quo = {lanes_i[i].quo[lsc_pkg::TW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r.valid <= 1'b0;
    end else if (en) begin
      side_r  <= side_i;
      lanes_r <= lanes_nxt;
    end
  end

  assign lanes_o = lanes_r;
  assign side_o  = side_r;

endmodule

[src/lsc_lerp.sv]
// Boundary resolution, endpoint interpolation and the result register.
module lsc_lerp (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  lsc_pkg::lanes_t lanes_i,
  input  lsc_pkg::side_t  side_i,
  output lsc_pkg::res_t   res_o
);

  localparam int CW = lsc_pkg::COORD_BITS;
  localparam int DW = lsc_pkg::DW;
  localparam int TW = lsc_pkg::TW;
  localparam int PW = lsc_pkg::PW;

  logic [TW-1:0] te_nxt, tx_nxt, te_r, tx_r;
  logic          ok_nxt, ok_r, c_valid_r;
  logic [CW-1:0] c_sx_r, c_sy_r, d_sx_r, d_sy_r;
  logic [DW-1:0] c_dx_r, c_dy_r;
  logic          d_valid_r, d_ok_r;
  logic [PW-1:0] px0_r, py0_r, px1_r, py1_r;
  lsc_pkg::res_t res_nxt, res_r;

  // Walk the boundaries in order left, right, bottom, top
  always_comb begin
    logic [TW-1:0] tm;
    logic          neg;
    te_nxt = '0;
    tx_nxt = lsc_pkg::T_ONE;
    ok_nxt = !side_i.rej;
    for (int i = 0; i < lsc_pkg::NB; i++) begin
      tm  = side_i.sat[i] ? lsc_pkg::T_SAT : lanes_i[i].quo;
      neg = side_i.tneg[i] && (tm != '0);
      if (!side_i.pz[i]) begin
        if (side_i.enter[i]) begin
          if (!neg && (tm > te_nxt)) te_nxt = tm;
        end else begin
          if (neg) ok_nxt = 1'b0;
          else if (tm < tx_nxt) tx_nxt = tm;
        end
        if (te_nxt > tx_nxt) ok_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
    end else if (en) begin
      c_valid_r <= side_i.valid;
      te_r      <= te_nxt;
      tx_r      <= tx_nxt;
      ok_r      <= ok_nxt;
      c_sx_r    <= side_i.sx;
      c_sy_r    <= side_i.sy;
      c_dx_r    <= side_i.dx;
      c_dy_r    <= side_i.dy;
      d_valid_r <= c_valid_r;
      d_ok_r    <= ok_r;
      d_sx_r    <= c_sx_r;
      d_sy_r    <= c_sy_r;
      px0_r     <= PW'($signed({1'b0, te_r}) * $signed(c_dx_r));
      py0_r     <= PW'($signed({1'b0, te_r}) * $signed(c_dy_r));
      px1_r     <= PW'($signed({1'b0, tx_r}) * $signed(c_dx_r));
      py1_r     <= PW'($signed({1'b0, tx_r}) * $signed(c_dy_r));
    end
  end

  function automatic logic [CW-1:0] round_add(input logic [CW-1:0] s, input logic [PW-1:0] p);
    logic [PW-1:0] v;
    logic [PW-1:0] sh;
    v  = p + lsc_pkg::T_HALF;
    sh = PW'($signed(v) >>> lsc_pkg::T_FRAC_BITS);
    return s + sh[CW-1:0];
  endfunction

  always_comb begin
    res_nxt.valid   = d_valid_r;
    res_nxt.visible = d_ok_r;
    res_nxt.x0      = d_ok_r ? round_add(d_sx_r, px0_r) : '0;
    res_nxt.y0      = d_ok_r ? round_add(d_sy_r, py0_r) : '0;
    res_nxt.x1      = d_ok_r ? round_add(d_sx_r, px1_r) : '0;
    res_nxt.y1      = d_ok_r ? round_add(d_sy_r, py1_r) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.valid <= 1'b0;
    end else if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res_o = res_r;

endmodule

[src/line_segment_clipper.sv]
// Top level of the Liang-Barsky line segment clipper.
//
//  channel  dir  handshake            payload
//  in_      in   in_tvalid/in_tready  tdata: start_x, start_y, end_x, end_y
//  out_     out  out_tvalid/out_tready tdata: clip_x0..clip_y1, tuser: visible
//  cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One segment per cycle unless the output stalls. Stages: input register, setup
// stage, one divider cell per quotient bit (T_FRAC_BITS + 1), resolve, multiply, result.
// The divider cell chain sets the latency; one transaction per cycle unless stalled.
// Reset restores the window registers and empties the pipeline.
// A stalled result register holds the whole pipeline; an empty one lets it advance.
module line_segment_clipper (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // start_x, start_y, end_x, end_y
  input  logic [lsc_pkg::DATA_W-1:0]          in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // clip_x0, clip_y0, clip_x1, clip_y1
  output logic [lsc_pkg::DATA_W-1:0]          out_tdata,
  // visible
  output logic                                out_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lsc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lsc_pkg::COORD_BITS-1:0]      cfg_data
);

  localparam int CW = lsc_pkg::COORD_BITS;
  localparam int DW = lsc_pkg::DW;
  localparam int TW = lsc_pkg::TW;

  logic [CW-1:0] x_min_r, x_max_r, y_min_r, y_max_r;
  logic          en;
  logic          a_valid_r;
  logic [CW-1:0] sx_r, sy_r, ex_r, ey_r;

  lsc_pkg::lanes_t front_lanes_nxt;
  lsc_pkg::side_t  front_side_nxt;
  lsc_pkg::lanes_t chain_lanes [TW+1];
  lsc_pkg::side_t  chain_side  [TW+1];
  lsc_pkg::res_t   res;

  assign en        = !res.valid || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r <= lsc_pkg::RST_X_MIN;
      x_max_r <= lsc_pkg::RST_X_MAX;
      y_min_r <= lsc_pkg::RST_Y_MIN;
      y_max_r <= lsc_pkg::RST_Y_MAX;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lsc_pkg::REG_X_MIN: x_min_r <= cfg_data;
        lsc_pkg::REG_X_MAX: x_max_r <= cfg_data;
        lsc_pkg::REG_Y_MIN: y_min_r <= cfg_data;
        lsc_pkg::REG_Y_MAX: y_max_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_tvalid;
      sx_r      <= in_tdata[CW-1:0];
      sy_r      <= in_tdata[2*CW-1:CW];
      ex_r      <= in_tdata[3*CW-1:2*CW];
      ey_r      <= in_tdata[4*CW-1:3*CW];
    end
  end

  // Form p and q per boundary and prime each divider lane
  always_comb begin
    logic [DW-1:0] sxe, sye, dx, dy;
    logic [DW-1:0] p [lsc_pkg::NB];
    logic [DW-1:0] q [lsc_pkg::NB];
    logic [DW-1:0] ap, aq;
    sxe = {sx_r[CW-1], sx_r};
    sye = {sy_r[CW-1], sy_r};
    dx  = {ex_r[CW-1], ex_r} - sxe;
    dy  = {ey_r[CW-1], ey_r} - sye;
    p[0] = -dx; q[0] = sxe - {x_min_r[CW-1], x_min_r};
    p[1] = dx;  q[1] = {x_max_r[CW-1], x_max_r} - sxe;
    p[2] = -dy; q[2] = sye - {y_min_r[CW-1], y_min_r};
    p[3] = dy;  q[3] = {y_max_r[CW-1], y_max_r} - sye;
    front_side_nxt.valid = a_valid_r;
    front_side_nxt.rej   = 1'b0;
    front_side_nxt.sx    = sx_r;
    front_side_nxt.sy    = sy_r;
    front_side_nxt.dx    = dx;
    front_side_nxt.dy    = dy;
    for (int i = 0; i < lsc_pkg::NB; i++) begin
      ap = p[i][DW-1] ? -p[i] : p[i];
      aq = q[i][DW-1] ? -q[i] : q[i];
      front_side_nxt.pz[i]    = (p[i] == '0);
      front_side_nxt.enter[i] = p[i][DW-1];
      front_side_nxt.tneg[i]  = p[i][DW-1] ^ q[i][DW-1];
      // a quotient of two or more always lands above 1.0
      front_side_nxt.sat[i]   = ({1'b0, aq} >= {ap, 1'b0});
      if ((p[i] == '0) && q[i][DW-1]) front_side_nxt.rej = 1'b1;
      front_lanes_nxt[i].dv  = ap;
      front_lanes_nxt[i].rem = {1'b0, aq[DW-1:1]};
      front_lanes_nxt[i].lsb = aq[0];
      front_lanes_nxt[i].quo = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_side[0].valid <= 1'b0;
    end else if (en) begin
      chain_side[0]  <= front_side_nxt;
      chain_lanes[0] <= front_lanes_nxt;
    end
  end

  for (genvar k = 0; k < TW; k++) begin : g_cell
    lsc_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .lanes_i (chain_lanes[k]),
      .side_i  (chain_side[k]),
      .lanes_o (chain_lanes[k+1]),
      .side_o  (chain_side[k+1])
    );
  end

  lsc_lerp u_lerp (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .lanes_i (chain_lanes[TW]),
    .side_i  (chain_side[TW]),
    .res_o   (res)
  );

  assign out_tvalid = res.valid;
  assign out_tuser  = res.visible;
  assign out_tdata  = lsc_pkg::DATA_W'({res.y1, res.x1, res.y0, res.x0});

endmodule

[tb/testbench.sv]
// Self-checking testbench for the Liang-Barsky line segment clipper.
`timescale 1ns / 1ps
module testbench;

  localparam int CW = lsc_pkg::COORD_BITS;
  localparam int TF = lsc_pkg::T_FRAC_BITS;
  localparam int BUS_W = lsc_pkg::DATA_W;
  localparam int IW = lsc_pkg::CFG_IDX_W;
  localparam int LIMIT = 3000000;
  localparam int N_RAND = 1350;
  localparam int DRAIN = TF + 30;

  typedef struct packed {
    logic          visible;
    logic [CW-1:0] x0;
    logic [CW-1:0] y0;
    logic [CW-1:0] x1;
    logic [CW-1:0] y1;
  } clip_t;

  typedef struct {
    logic [CW-1:0] sx, sy, ex, ey;
    bit            known;
    clip_t         want;
  } seg_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic [BUS_W-1:0] in_tdata = '0;
  logic in_tready;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [BUS_W-1:0] out_tdata;
  logic out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IW-1:0] cfg_index = '0;
  logic [CW-1:0] cfg_data = '0;

  line_segment_clipper dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // window copy used for prediction
  logic signed [CW-1:0] wx_lo, wx_hi, wy_lo, wy_hi;
  clip_t clips_due[$];
  int errors = 0, n_sent = 0, n_got = 0, n_vis = 0;
  longint cycles = 0;
  bit hold_off = 1'b0;
  bit sending_done = 1'b0;

  function automatic longint floor_shift(longint v);
    return (v >= 0) ? (v >>> TF) : ~((~v) >>> TF);
  endfunction

  function automatic clip_t clip_segment(logic [CW-1:0] sx_b, sy_b, ex_b, ey_b);
    longint sx, sy, dx, dy, p, q, t, t_in, t_out;
    longint pl[4], ql[4];
    bit ok;
    clip_t r;
    sx = longint'($signed(sx_b));
    sy = longint'($signed(sy_b));
    dx = longint'($signed(ex_b)) - sx;
    dy = longint'($signed(ey_b)) - sy;
    pl[0] = -dx; ql[0] = sx - longint'(wx_lo);
    pl[1] = dx;  ql[1] = longint'(wx_hi) - sx;
    pl[2] = -dy; ql[2] = sy - longint'(wy_lo);
    pl[3] = dy;  ql[3] = longint'(wy_hi) - sy;
    t_in = 0;
    t_out = longint'(1) << TF;
    ok = 1'b1;
    for (int i = 0; i < 4 && ok; i++) begin
      p = pl[i];
      q = ql[i];
      if (p == 0) begin
        if (q < 0) ok = 1'b0;
        continue;
      end
      t = (q * (longint'(1) << TF)) / p;
      if (p < 0) begin
        if (t > t_in) t_in = t;
      end else if (t < t_out) begin
        t_out = t;
      end
      if (t_in > t_out) ok = 1'b0;
    end
    r = '0;
    if (ok) begin
      r.visible = 1'b1;
      r.x0 = CW'(sx + floor_shift(t_in * dx + (longint'(1) << (TF - 1))));
      r.y0 = CW'(sy + floor_shift(t_in * dy + (longint'(1) << (TF - 1))));
      r.x1 = CW'(sx + floor_shift(t_out * dx + (longint'(1) << (TF - 1))));
      r.y1 = CW'(sy + floor_shift(t_out * dy + (longint'(1) << (TF - 1))));
    end
    return r;
  endfunction

  task automatic write_window_reg(logic [IW-1:0] idx, logic [CW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      lsc_pkg::REG_X_MIN: wx_lo = val;
      lsc_pkg::REG_X_MAX: wx_hi = val;
      lsc_pkg::REG_Y_MIN: wy_lo = val;
      lsc_pkg::REG_Y_MAX: wy_hi = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_window(logic [CW-1:0] xl, xh, yl, yh);
    write_window_reg(lsc_pkg::REG_X_MIN, xl);
    write_window_reg(lsc_pkg::REG_X_MAX, xh);
    write_window_reg(lsc_pkg::REG_Y_MIN, yl);
    write_window_reg(lsc_pkg::REG_Y_MAX, yh);
  endtask

  task automatic wait_quiet();
    while (clips_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // sends one segment; keeps tvalid high into the next when there is no gap
  task automatic send_segment(logic [CW-1:0] sx, sy, ex, ey, bit known, clip_t want);
    clip_t pred;
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    if ($urandom_range(0, 9) < 4) gap = 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {ey, ex, sy, sx};
    do @(posedge clk); while (!in_tready);
    pred = clip_segment(sx, sy, ex, ey);
    if (known && pred != want)
      $display("note: table row %0d disagrees with prediction", n_sent);
    clips_due.push_back(known ? want : pred);
    n_sent++;
  endtask

  function automatic logic [CW-1:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return CW'($urandom);
      1: return CW'($urandom_range(0, 1) ? 16'h7fff : 16'h8000);
      default: return CW'($signed(wx_lo) + $signed(17'($urandom_range(0, 2000))) - 17'sd500);
    endcase
  endfunction

  task automatic random_phase(int n);
    logic [CW-1:0] a, b, c, d;
    for (int i = 0; i < n; i++) begin
      a = pick_coord(); b = pick_coord(); c = pick_coord(); d = pick_coord();
      if ($urandom_range(0, 19) == 0) begin c = a; d = b; end
      if ($urandom_range(0, 19) == 0) c = a;
      if ($urandom_range(0, 19) == 0) d = b;
      send_segment(a, b, c, d, 1'b0, '0);
    end
    in_tvalid <= 1'b0;
  endtask

  // result side: random stall per transaction plus one long hold-off
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if ($urandom_range(0, 9) < 4) stall = 0;
      if (stall != 0 || hold_off) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
        while (hold_off) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // compare every accepted result against the oldest expectation
  always @(posedge clk) begin
    clip_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata[CW-1:0], out_tdata[2*CW-1:CW],
             out_tdata[3*CW-1:2*CW], out_tdata[4*CW-1:3*CW]};
      n_got++;
      if (got.visible) n_vis++;
      if (clips_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
      end else begin
        want = clips_due.pop_front();
        if (got != want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: vis %b/%b x0 %0d/%0d y0 %0d/%0d x1 %0d/%0d y1 %0d/%0d",
                     want.visible, got.visible, $signed(want.x0), $signed(got.x0),
                     $signed(want.y0), $signed(got.y0), $signed(want.x1),
                     $signed(got.x1), $signed(want.y1), $signed(got.y1));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  seg_row_t rows[$];

  function automatic seg_row_t mk(int sx, sy, ex, ey, bit known, clip_t w);
    seg_row_t r;
    r.sx = CW'(sx); r.sy = CW'(sy); r.ex = CW'(ex); r.ey = CW'(ey);
    r.known = known; r.want = w;
    return r;
  endfunction

  initial begin
    wx_lo = lsc_pkg::RST_X_MIN; wx_hi = lsc_pkg::RST_X_MAX;
    wy_lo = lsc_pkg::RST_Y_MIN; wy_hi = lsc_pkg::RST_Y_MAX;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table against the reset window
    rows.push_back(mk(10, 20, 100, 200, 1, '{1'b1, 10, 20, 100, 200}));
    rows.push_back(mk(5, 5, 5, 5, 1, '{1'b1, 5, 5, 5, 5}));
    rows.push_back(mk(-5, 5, -5, 5, 1, '0));
    rows.push_back(mk(-10, 100, -10, 300, 1, '0));
    rows.push_back(mk(100, 900, 300, 900, 1, '0));
    rows.push_back(mk(-100, 100, 1400, 100, 1, '{1'b1, 0, 100, 1279, 100}));
    rows.push_back(mk(100, -50, 100, 900, 1, '{1'b1, 100, 0, 100, 799}));
    rows.push_back(mk(1279, 799, 0, 0, 1, '{1'b1, 1279, 799, 0, 0}));
    rows.push_back(mk(-32768, -32768, 32767, 32767, 0, '0));
    rows.push_back(mk(32767, 32767, -32768, -32768, 0, '0));
    rows.push_back(mk(-32768, 32767, 32767, -32768, 1, '0));
    rows.push_back(mk(-2000, 400, 3000, 401, 0, '0));
    rows.push_back(mk(-300, -300, 1500, 1100, 0, '0));
    rows.push_back(mk(2000, 2000, 2000, 2000, 1, '0));
    rows.push_back(mk(0, 0, -1, -1, 1, '{1'b1, 0, 0, 0, 0}));
    rows.push_back(mk(640, -100, 700, 1000, 0, '0));
    foreach (rows[i]) send_segment(rows[i].sx, rows[i].sy, rows[i].ex, rows[i].ey,
                                   rows[i].known, rows[i].want);
    in_tvalid <= 1'b0;
    wait_quiet();

    // random with the reset window, including a long receiver hold-off
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      random_phase(N_RAND / 5);
    join
    wait_quiet();

    set_window(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    random_phase(N_RAND / 5);
    wait_quiet();
    set_window(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    random_phase(N_RAND / 10);
    wait_quiet();
    set_window(16'sd500, 16'sd100, 16'sd600, 16'sd200);  // inverted window
    random_phase(N_RAND / 10);
    wait_quiet();
    write_window_reg(IW'(9), 16'h1234);                   // ignored index
    set_window(-16'sd400, 16'sd900, -16'sd300, 16'sd250);
    random_phase(N_RAND / 5);
    wait_quiet();
    set_window(CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom));
    random_phase(N_RAND / 10);
    wait_quiet();
    set_window(-16'sd1000, 16'sd1000, -16'sd1000, 16'sd1000);
    random_phase(N_RAND / 10);
    wait_quiet();

    $display("Clipped %0d segments over seven windows, %0d visible, %0d rejected.",
             n_got, n_vis, n_got - n_vis);
    $display("Sent %0d, mismatches %0d.", n_sent, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
